>>> rtl/core/mpq_pkg.sv
// mpq_pkg: shared types and constants for the min priority queue
// entry, item and result structs, state and code enums; no dependencies
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int COUNT_W      = 7;
    localparam int KEY_W        = 32;
    localparam int ARRIVAL_W    = 16;
    localparam int TAG_W        = 16;

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_REMOVED  = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    // field order makes a plain unsigned compare give the ranking
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [ARRIVAL_W-1:0] arrival;
        logic [TAG_W-1:0]     tag;
    } entry_t;

    typedef struct packed {
        action_t              action;
        logic [KEY_W-1:0]     key;
        logic [ARRIVAL_W-1:0] arrival;
        logic [TAG_W-1:0]     tag;
    } in_t;

    typedef struct packed {
        status_t              status;
        logic [KEY_W-1:0]     out_key;
        logic [ARRIVAL_W-1:0] out_arrival;
        logic [TAG_W-1:0]     out_tag;
        logic [COUNT_W-1:0]   count;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHECK,
        S_UP_CMP,
        S_RM_LOAD,
        S_DN_READ,
        S_DN_CHILD,
        S_DN_MOVE,
        S_DONE
    } state_t;

endpackage

>>> rtl/core/mpq_cmp.sv
// mpq_cmp: shared ranking comparator, key then arrival then tag
// depends on mpq_pkg for entry_t
`timescale 1ns / 1ps

module mpq_cmp
    import mpq_pkg::*;
(
    input  entry_t a,
    input  entry_t b,
    output logic   a_first
);

    // strict order; identical entries do not rank before each other
    assign a_first = (a < b);

endmodule

>>> rtl/core/mpq_mem.sv
// mpq_mem: heap entry storage, one write port and two registered read ports
// depends on mpq_pkg for entry_t
`timescale 1ns / 1ps

module mpq_mem
    import mpq_pkg::*;
#(
    parameter int DEPTH = DEF_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output entry_t        rdata_a,
    output entry_t        rdata_b
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> rtl/core/min_priority_queue_core.sv
// states from accept to result: an error goes straight to S_DONE; an insert loops
// S_UP_CHECK, S_UP_CMP per heap level climbed; a remove runs S_RM_LOAD, then loops
// S_DN_READ, S_DN_CHILD, S_DN_MOVE per level sunk; S_DONE holds while a result stalls
// throughput: one item at a time, set by the shared comparator and memory ports
// reset: asynchronous active low, queue empty, no result pending
// depends on mpq_pkg, mpq_cmp, mpq_mem
`timescale 1ns / 1ps

module min_priority_queue_core
    import mpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = CW + 1;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] hole_reg, hole_next;
    logic [AW-1:0] par_reg, par_next;
    logic [AW-1:0] cidx_reg, cidx_next;
    entry_t        x_reg, x_next;
    entry_t        child_reg, child_next;
    out_t          res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    out_t          out_data_reg, out_data_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
    entry_t        mem_wdata, rdata_a, rdata_b;

    entry_t        cmp_a, cmp_b;
    logic          a_first;

    logic [LW-1:0] left_idx, right_idx;
    entry_t        in_entry;

    mpq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    mpq_cmp u_cmp (
        .a       (cmp_a),
        .b       (cmp_b),
        .a_first (a_first)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign left_idx  = (LW'(hole_reg) << 1) + LW'(1);
    assign right_idx = left_idx + LW'(1);
    assign in_entry  = '{key: in_data.key, arrival: in_data.arrival, tag: in_data.tag};

    // operand select for the one comparator
    always_comb
    begin
        cmp_a = x_reg;
        cmp_b = rdata_a;
        case (state_reg)
            S_DN_CHILD:
            begin
                cmp_a = rdata_b;
                cmp_b = rdata_a;
            end
            S_DN_MOVE:
            begin
                cmp_a = child_reg;
                cmp_b = x_reg;
            end
            default:
            begin
                cmp_a = x_reg;
                cmp_b = rdata_a;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg     <= hole_next;
        par_reg      <= par_next;
        cidx_reg     <= cidx_next;
        x_reg        <= x_next;
        child_reg    <= child_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        hole_next      = hole_reg;
        par_next       = par_reg;
        cidx_next      = cidx_reg;
        x_next         = x_reg;
        child_next     = child_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = hole_reg;
        mem_wdata      = x_reg;
        mem_re         = 1'b0;
        mem_raddr_a    = '0;
        mem_raddr_b    = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                res_next = '0;
                if (in_valid)
                begin
                    if (in_data.action == ACT_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            res_next.status = STAT_FULL;
                            res_next.count  = COUNT_W'(count_reg);
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            x_next          = in_entry;
                            hole_next       = AW'(count_reg);
                            count_next      = count_reg + CW'(1);
                            res_next.status = STAT_INSERTED;
                            res_next.count  = COUNT_W'(count_reg + CW'(1));
                            state_next      = S_UP_CHECK;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = STAT_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // root is the result, last entry refills the hole
                            mem_re          = 1'b1;
                            mem_raddr_a     = '0;
                            mem_raddr_b     = AW'(count_reg - CW'(1));
                            count_next      = count_reg - CW'(1);
                            res_next.status = STAT_REMOVED;
                            res_next.count  = COUNT_W'(count_reg - CW'(1));
                            state_next      = S_RM_LOAD;
                        end
                    end
                end
            end

            S_UP_CHECK:
            begin
                if (hole_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    par_next    = (hole_reg - AW'(1)) >> 1;
                    mem_re      = 1'b1;
                    mem_raddr_a = (hole_reg - AW'(1)) >> 1;
                    state_next  = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (a_first)
                begin
                    // parent moves down into the hole
                    mem_wdata  = rdata_a;
                    hole_next  = par_reg;
                    state_next = S_UP_CHECK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_RM_LOAD:
            begin
                res_next.out_key     = rdata_a.key;
                res_next.out_arrival = rdata_a.arrival;
                res_next.out_tag     = rdata_a.tag;
                x_next               = rdata_b;
                hole_next            = '0;
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_READ;
                end
            end

            S_DN_READ:
            begin
                if (left_idx >= LW'(count_reg))
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re      = 1'b1;
                    mem_raddr_a = AW'(left_idx);
                    mem_raddr_b = AW'(right_idx);
                    state_next  = S_DN_CHILD;
                end
            end

            S_DN_CHILD:
            begin
                if ((right_idx < LW'(count_reg)) && a_first)
                begin
                    child_next = rdata_b;
                    cidx_next  = AW'(right_idx);
                end
                else
                begin
                    child_next = rdata_a;
                    cidx_next  = AW'(left_idx);
                end
                state_next = S_DN_MOVE;
            end

            S_DN_MOVE:
            begin
                mem_we = 1'b1;
                if (a_first)
                begin
                    // smaller child moves up into the hole
                    mem_wdata  = child_reg;
                    hole_next  = cidx_reg;
                    state_next = S_DN_READ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/mpq_checker.sv
// mpq_checker: port-level assertions for min_priority_queue_core, bound below
// depends on mpq_pkg for result and status types
`timescale 1ns / 1ps

module mpq_checker
    import mpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken in back-to-back cycles");

    // only a removal carries an entry
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != STAT_REMOVED)
        |-> (out_data.out_key == '0) && (out_data.out_arrival == '0)
            && (out_data.out_tag == '0))
        else $error("nonzero entry on a non-removal result");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STAT_EMPTY) |-> out_data.count == '0)
        else $error("empty error with nonzero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STAT_FULL)
        |-> out_data.count == COUNT_W'(CAPACITY))
        else $error("full error with count below capacity");

endmodule

bind min_priority_queue_core mpq_checker #(.CAPACITY(CAPACITY)) u_mpq_checker (.*);

>>> dv/testbench.sv
// testbench for min_priority_queue_core: directed and random insert/remove traffic
// checked against a behavioral queue model kept in this file; depends on mpq_pkg
`timescale 1ns / 1ps

module testbench;
    import mpq_pkg::*;

    localparam int DEPTH        = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 40;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    bit   no_idle = 1'b0;
    int   errors  = 0;

    // behavioral copy of the queue contents
    entry_t held [DEPTH];
    int     held_count = 0;
    int     peak_count = 0;
    out_t   pending_results[$];

    int n_inserted = 0;
    int n_removed  = 0;
    int n_empty    = 0;
    int n_full     = 0;

    min_priority_queue_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 50)
        begin
            $display("mismatch @%0t: %s", $realtime, what);
        end
    endtask

    // key first, then arrival stamp, then tag
    function automatic bit ranks_first(input entry_t a, input entry_t b);
        if (a.key != b.key)
            return a.key < b.key;
        if (a.arrival != b.arrival)
            return a.arrival < b.arrival;
        return a.tag < b.tag;
    endfunction

    function automatic out_t apply_to_queue(input in_t item);
        out_t   r;
        entry_t fresh;
        int     best;
        int     i;
        r = '0;
        if (item.action == ACT_INSERT)
        begin
            if (held_count >= DEPTH)
            begin
                r.status = STAT_FULL;
            end
            else
            begin
                fresh.key         = item.key;
                fresh.arrival     = item.arrival;
                fresh.tag         = item.tag;
                held[held_count]  = fresh;
                held_count++;
                r.status = STAT_INSERTED;
            end
        end
        else if (held_count == 0)
        begin
            r.status = STAT_EMPTY;
        end
        else
        begin
            best = 0;
            for (i = 1; i < held_count; i++)
            begin
                if (ranks_first(held[i], held[best]))
                    best = i;
            end
            r.out_key     = held[best].key;
            r.out_arrival = held[best].arrival;
            r.out_tag     = held[best].tag;
            held[best]    = held[held_count - 1];
            held_count--;
            r.status = STAT_REMOVED;
        end
        r.count = COUNT_W'(held_count);
        if (held_count > peak_count)
            peak_count = held_count;
        return r;
    endfunction

    // offer one item, with an occasional gap, and log its expected result on acceptance
    task automatic send_item(input in_t item);
        if (!no_idle && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 40);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_to_queue(item));
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
        end
    endtask

    function automatic in_t make_insert(input logic [KEY_W-1:0] key,
                                        input logic [ARRIVAL_W-1:0] arrival,
                                        input logic [TAG_W-1:0] tag);
        in_t item;
        item.action  = ACT_INSERT;
        item.key     = key;
        item.arrival = arrival;
        item.tag     = tag;
        return item;
    endfunction

    // remove ignores the entry fields, so fill them with junk
    function automatic in_t make_remove();
        in_t item;
        item.action  = ACT_REMOVE;
        item.key     = $urandom;
        item.arrival = 16'($urandom);
        item.tag     = 16'($urandom);
        return item;
    endfunction

    // narrow ranges make ties common, wide ones exercise every bit
    function automatic logic [KEY_W-1:0] pick_key();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return KEY_W'($urandom_range(7));
        if (pick < 8)
            return $urandom;
        return pick[0] ? '1 : '0;
    endfunction

    function automatic logic [15:0] pick_stamp();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return 16'($urandom_range(3));
        if (pick < 9)
            return 16'($urandom);
        return 16'hffff;
    endfunction

    task automatic test_empty_remove();
        send_item(make_remove());
        send_item(make_remove());
        wait_drained();
    endtask

    task automatic test_field_extremes();
        send_item(make_insert('1, '1, '1));
        send_item(make_insert('0, '0, '0));
        send_item(make_insert(32'h8000_0000, 16'h8000, 16'h8000));
        send_item(make_insert(32'h7fff_ffff, 16'h7fff, 16'h7fff));
        repeat (4)
            send_item(make_remove());
        send_item(make_remove());
        wait_drained();
    endtask

    task automatic test_tie_breaks();
        send_item(make_insert(32'd5, 16'd9, 16'd3));
        send_item(make_insert(32'd5, 16'd2, 16'd7));
        send_item(make_insert(32'd5, 16'd2, 16'd1));
        // identical entries: either copy may leave first, result is the same
        send_item(make_insert(32'd5, 16'd2, 16'd1));
        send_item(make_insert(32'd4, 16'hffff, 16'hffff));
        send_item(make_insert(32'd5, 16'd9, 16'd2));
        repeat (6)
            send_item(make_remove());
        wait_drained();
    endtask

    task automatic test_full_queue();
        int i;
        for (i = 0; i < DEPTH; i++)
            send_item(make_insert(pick_key(), pick_stamp(), pick_stamp()));
        send_item(make_insert(pick_key(), pick_stamp(), pick_stamp()));
        send_item(make_insert('1, '1, '1));
        for (i = 0; i < DEPTH; i++)
            send_item(make_remove());
        send_item(make_remove());
        wait_drained();
    endtask

    task automatic test_random_mix();
        int n;
        int insert_pct;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // swing the queue between full and empty over the run
            case (n / 150)
                0:       insert_pct = 80;
                1:       insert_pct = 20;
                2:       insert_pct = 60;
                default: insert_pct = 25;
            endcase
            no_idle = (n >= 200 && n < 300);
            if ($urandom_range(99) < insert_pct)
                send_item(make_insert(pick_key(), pick_stamp(), pick_stamp()));
            else
                send_item(make_remove());
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(99) >= 15);
    end

    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: %h", out_data));
            end
            else
            begin
                want = pending_results.pop_front();
                case (want.status)
                    STAT_INSERTED: n_inserted++;
                    STAT_REMOVED:  n_removed++;
                    STAT_EMPTY:    n_empty++;
                    default:       n_full++;
                endcase
                if (out_data.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                        out_data.status, want.status));
                if (out_data.out_key !== want.out_key)
                    report_mismatch($sformatf("out_key %h, want %h",
                        out_data.out_key, want.out_key));
                if (out_data.out_arrival !== want.out_arrival)
                    report_mismatch($sformatf("out_arrival %h, want %h",
                        out_data.out_arrival, want.out_arrival));
                if (out_data.out_tag !== want.out_tag)
                    report_mismatch($sformatf("out_tag %h, want %h",
                        out_data.out_tag, want.out_tag));
                if (out_data.count !== want.count)
                    report_mismatch($sformatf("count %0d, want %0d",
                        out_data.count, want.count));
            end
        end
    end

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_remove();
        test_field_extremes();
        test_tie_breaks();
        test_full_queue();
        test_random_mix();

        repeat (SETTLE)
            @(posedge clk);

        $display("covered %0d inserts, %0d removes, %0d empty and %0d full rejections",
            n_inserted, n_removed, n_empty, n_full);
        $display("deepest queue seen: %0d of %0d entries", peak_count, DEPTH);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
